@@ src/ffsa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and codes of the first-fit segment allocator: channel
// payloads, status codes, controller states and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package ffsa_pkg;

   localparam int FIELD_W  = 11;
   localparam int OFFSET_W = 10;
   localparam int STATUS_W = 2;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOFIT    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd3;

   typedef struct packed {
      logic                req_type;
      logic [FIELD_W-1:0]  alloc_size;
      logic [FIELD_W-1:0]  free_offset;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OFFSET_W-1:0] alloc_offset;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      FS_IDLE,
      FS_SCAN,
      FS_SHIFT,
      FS_WR_HIT,
      FS_WR_NEW,
      FS_WR_FREE,
      FS_DONE
   } ffsa_state_type;

   typedef struct packed {
      logic load_req;   // latch request, read entry 0
      logic scan_rd;    // read next entry of the scan
      logic capture;    // latch the matching entry
      logic shift_rd;   // read one entry to move up a place
      logic wr_hit;     // write back the shrunk free entry
      logic wr_new;     // write the new allocated entry, bump count
      logic wr_free;    // write back the freed entry
   } ffsa_cmd_type;

   typedef struct packed {
      logic is_free;
      logic in_range;
      logic match;
      logic full;
      logic shift_done;
   } ffsa_stat_type;

endpackage

@@ src/first_fit_segment_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit allocator over an ordered segment table with insertion shift.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: an allocate (size) or a free (offset).
//   rsp_* returns exactly one item per request: status and, on a good
//   allocate, the pool offset of the new segment (zero otherwise).
//   Items are handled one at a time. An item scans the table one entry a
//   cycle through the table memory's single read port; an allocate then
//   moves the entries above the hit up one place per cycle.
//   The result sits in an output register; a new item is accepted while it
//   waits, and that item's result is held back until the receiver takes
//   the earlier one. A stall on rsp_ready only delays, never drops.
//   Reset returns the table to one free segment covering the whole pool;
//   no clearing pass is needed and the block is ready the cycle after.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator
   import ffsa_pkg::*;
#(
   parameter int MEM_BYTES    = 1024,
   parameter int MAX_SEGMENTS = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   ffsa_cmd_type        cmd;
   ffsa_stat_type       stat;
   logic [OFFSET_W-1:0] base_offset;
   logic                out_free;
   logic                rsp_load;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_with_offset;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_data_ff, rsp_data_in;

   ffsa_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .out_free        (out_free),
      .rsp_load        (rsp_load),
      .rsp_status      (rsp_status),
      .rsp_with_offset (rsp_with_offset),
      .cmd             (cmd),
      .stat            (stat)
   );

   ffsa_datapath #(
      .MEM_BYTES    (MEM_BYTES),
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_data),
      .stat        (stat),
      .base_offset (base_offset)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.status        = rsp_status;
         rsp_data_in.alloc_offset  = rsp_with_offset ? base_offset : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // one item at a time: no accept right after an accept
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous item in flight");

   // never overwrite a result that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending result");

   // offset is reported only with ok status
   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_OK) |-> (rsp_data.alloc_offset == '0))
      else $error("nonzero offset on error status");
`endif

endmodule

@@ src/ffsa_datapath.sv @@
// ----------------------------------------------------------------------------
// ffsa_datapath
// Segment table memory, scan and shift pointers, hit capture and the
// entry update arithmetic.
// ----------------------------------------------------------------------------
module ffsa_datapath
   import ffsa_pkg::*;
#(
   parameter int MEM_BYTES    = 1024,
   parameter int MAX_SEGMENTS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  ffsa_cmd_type        cmd,
   input  req_payload_type     req_data,
   output ffsa_stat_type       stat,
   output logic [OFFSET_W-1:0] base_offset
);

   localparam int DW    = $clog2(MEM_BYTES + 1);
   localparam int IW    = $clog2(MAX_SEGMENTS);
   localparam int CW    = $clog2(MAX_SEGMENTS + 1);
   localparam int EW    = 2 * DW + 1;
   localparam int CMP_W = (DW > FIELD_W) ? DW : FIELD_W;
   localparam logic [EW-1:0] INIT_ENTRY = {DW'(0), DW'(MEM_BYTES), 1'b0};

   logic [EW-1:0]      mem [MAX_SEGMENTS];
   logic [EW-1:0]      rd_data_ff;
   logic [CW-1:0]      rd_idx_ff;
   logic [CW-1:0]      rd_addr;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               e0_valid_ff, e0_valid_in;
   logic               sh_pend_ff;
   logic               is_free_ff, is_free_in;
   logic [FIELD_W-1:0] want_ff, want_in;
   logic [FIELD_W-1:0] where_ff, where_in;
   logic [CW-1:0]      hit_ff, hit_in;
   logic [DW-1:0]      base_ff, base_in;
   logic [DW-1:0]      hsize_ff, hsize_in;

   logic [EW-1:0]      cur_entry;
   logic [DW-1:0]      cur_start, cur_size;
   logic               cur_used;
   logic               wr_en;
   logic [CW-1:0]      wr_addr;
   logic [EW-1:0]      wr_entry;
   logic [CMP_W-1:0]   base_ext;

   assign rd_addr = cmd.load_req ? '0 : ptr_ff;

   // entry 0 reads as the whole free pool until it is first written
   assign cur_entry = (rd_idx_ff == '0 && !e0_valid_ff) ? INIT_ENTRY : rd_data_ff;
   assign cur_start = cur_entry[EW-1:DW+1];
   assign cur_size  = cur_entry[DW:1];
   assign cur_used  = cur_entry[0];

   assign stat.is_free    = is_free_ff;
   assign stat.in_range   = rd_idx_ff < count_ff;
   assign stat.match      = is_free_ff ? (CMP_W'(cur_start) == CMP_W'(where_ff))
                                       : (!cur_used && CMP_W'(cur_size) >= CMP_W'(want_ff));
   assign stat.full       = count_ff == CW'(MAX_SEGMENTS);
   assign stat.shift_done = ptr_ff <= hit_ff;

   assign base_ext    = CMP_W'(base_ff);
   assign base_offset = base_ext[OFFSET_W-1:0];

   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = hit_ff;
      wr_entry = {base_ff, hsize_ff, 1'b0};
      priority if (sh_pend_ff) begin
         // move the entry read last cycle up one place
         wr_en    = 1'b1;
         wr_addr  = CW'(rd_idx_ff + 1'b1);
         wr_entry = cur_entry;
      end else if (cmd.wr_hit) begin
         wr_en    = 1'b1;
         wr_entry = {DW'(base_ff + DW'(want_ff)), DW'(hsize_ff - DW'(want_ff)), 1'b0};
      end else if (cmd.wr_free) begin
         wr_en    = 1'b1;
      end else if (cmd.wr_new) begin
         wr_en    = 1'b1;
         wr_addr  = CW'(hit_ff + 1'b1);
         wr_entry = {base_ff, DW'(want_ff), 1'b1};
      end
   end

   always_comb begin
      ptr_in      = ptr_ff;
      count_in    = count_ff;
      e0_valid_in = e0_valid_ff | (wr_en && wr_addr == '0);
      is_free_in  = is_free_ff;
      want_in     = want_ff;
      where_in    = where_ff;
      hit_in      = hit_ff;
      base_in     = base_ff;
      hsize_in    = hsize_ff;
      if (cmd.load_req) begin
         ptr_in     = CW'(1);
         is_free_in = req_data.req_type == REQ_FREE;
         want_in    = req_data.alloc_size;
         where_in   = req_data.free_offset;
      end
      if (cmd.scan_rd) begin
         ptr_in = CW'(ptr_ff + 1'b1);
      end
      if (cmd.capture) begin
         hit_in   = rd_idx_ff;
         base_in  = cur_start;
         hsize_in = cur_size;
         ptr_in   = CW'(count_ff - 1'b1);
      end
      if (cmd.shift_rd) begin
         ptr_in = CW'(ptr_ff - 1'b1);
      end
      if (cmd.wr_new) begin
         count_in = CW'(count_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff      <= '0;
         count_ff    <= CW'(1);
         e0_valid_ff <= 1'b0;
         sh_pend_ff  <= 1'b0;
      end else begin
         ptr_ff      <= ptr_in;
         count_ff    <= count_in;
         e0_valid_ff <= e0_valid_in;
         sh_pend_ff  <= cmd.shift_rd;
      end
   end

   always_ff @(posedge clock) begin
      is_free_ff <= is_free_in;
      want_ff    <= want_in;
      where_ff   <= where_in;
      hit_ff     <= hit_in;
      base_ff    <= base_in;
      hsize_ff   <= hsize_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr[IW-1:0]] <= wr_entry;
      end
      rd_data_ff <= mem[rd_addr[IW-1:0]];
      rd_idx_ff  <= rd_addr;
   end

endmodule

@@ src/ffsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Sequencer of the allocator: scan, shift, entry writes and result hand-off.
// ----------------------------------------------------------------------------
module ffsa_ctrl
   import ffsa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                out_free,
   output logic                rsp_load,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_with_offset,
   output ffsa_cmd_type        cmd,
   input  ffsa_stat_type       stat
);

   ffsa_state_type      state_ff, state_in;
   logic [STATUS_W-1:0] code_ff, code_in;
   logic                with_off_ff, with_off_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      with_off_ff <= with_off_in;
   end

   assign rsp_status      = code_ff;
   assign rsp_with_offset = with_off_ff;

   always_comb begin
      state_in    = state_ff;
      code_in     = code_ff;
      with_off_in = with_off_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      rsp_load    = 1'b0;
      unique case (state_ff)
         FS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = FS_SCAN;
            end
         end
         FS_SCAN: begin
            with_off_in = 1'b0;
            priority if (!stat.in_range) begin
               code_in  = stat.is_free ? STATUS_NOTFOUND : STATUS_NOFIT;
               state_in = FS_DONE;
            end else if (stat.match) begin
               cmd.capture = 1'b1;
               priority if (stat.is_free) begin
                  state_in = FS_WR_FREE;
               end else if (stat.full) begin
                  code_in  = STATUS_FULL;
                  state_in = FS_DONE;
               end else begin
                  state_in = FS_SHIFT;
               end
            end else begin
               cmd.scan_rd = 1'b1;
            end
         end
         FS_SHIFT: begin
            if (stat.shift_done) begin
               state_in = FS_WR_HIT;
            end else begin
               cmd.shift_rd = 1'b1;
            end
         end
         FS_WR_HIT: begin
            cmd.wr_hit = 1'b1;
            state_in   = FS_WR_NEW;
         end
         FS_WR_NEW: begin
            cmd.wr_new  = 1'b1;
            code_in     = STATUS_OK;
            with_off_in = 1'b1;
            state_in    = FS_DONE;
         end
         FS_WR_FREE: begin
            cmd.wr_free = 1'b1;
            code_in     = STATUS_OK;
            state_in    = FS_DONE;
         end
         FS_DONE: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = FS_IDLE;
            end
         end
         default: begin
            state_in = FS_IDLE;
         end
      endcase
   end

endmodule
